FILE: sv/fraction_sum_parser_assert.svh
// ---------------------------------------------------------------------------
// fraction_sum_parser assertion macros
// Concurrent check wrappers; compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef FRACTION_SUM_PARSER_ASSERT_SVH
`define FRACTION_SUM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define FSP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FSP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define FSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/fsp_pkg.sv
// ---------------------------------------------------------------------------
// fsp_pkg
// Shared constants and types of the fraction sum parser.
// ---------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

    localparam int VALUE_WIDTH = 32;
    // power of two: queue pointers wrap by overflow
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam int RADIX = 10;

    typedef struct packed {
        logic neg;    // fraction is negative
        logic ovf;    // digit accumulation saturated
        logic last;   // fraction closes the expression
    } cmd_flags_t;

endpackage

`default_nettype wire

FILE: sv/fsp_div.sv
// ---------------------------------------------------------------------------
// fsp_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module fsp_div #(
    parameter int W = 2 * fsp_pkg::VALUE_WIDTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic      [W-1:0] quotient,
    output logic              done
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg[W-1:0], q_reg[W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            q_next    = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = shifted - {1'b0, dvs_reg};
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

FILE: sv/fsp_front.sv
// ---------------------------------------------------------------------------
// fsp_front
// Character parser: sign, numerator and denominator digits, fraction ends.
// ---------------------------------------------------------------------------
`default_nettype none

module fsp_front #(
    parameter int VALUE_WIDTH = fsp_pkg::VALUE_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] ch
    input  wire logic                     s_tlast,
    input  wire logic                     q_space,
    output logic                          wr0_en,
    output logic [VALUE_WIDTH-2:0]        wr0_num,
    output logic [VALUE_WIDTH-2:0]        wr0_den,
    output fsp_pkg::cmd_flags_t           wr0_flags,
    output logic                          wr1_en,
    output logic [VALUE_WIDTH-2:0]        wr1_num,
    output logic [VALUE_WIDTH-2:0]        wr1_den,
    output fsp_pkg::cmd_flags_t           wr1_flags
);
    localparam int MW = VALUE_WIDTH - 1;
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_NUM   = 2'd1;
    localparam logic [1:0] PH_DEN   = 2'd2;
    localparam logic [MW+3:0] MAXV  = (MW+4)'({MW{1'b1}});

    logic [1:0]    phase_reg, phase_next;
    logic [MW-1:0] pn_reg, pn_next, pd_reg, pd_next;
    logic          neg_reg, neg_next, ov_reg, ov_next;
    logic          accept, is_dig, do_start;
    logic [MW:0]   sum_pn, sum_pd;

    // returns {saturated, value}
    function automatic logic [MW:0] add_digit(input logic [MW-1:0] acc, input logic [7:0] c);
        logic [MW+3:0] v;
        v = (MW+4)'(acc) * (MW+4)'(fsp_pkg::RADIX) + (MW+4)'(c[3:0]);
        if (v > MAXV)
            add_digit = {1'b1, MAXV[MW-1:0]};
        else
            add_digit = {1'b0, v[MW-1:0]};
    endfunction

    assign s_tready = q_space;
    assign accept   = s_tvalid && q_space;
    assign is_dig   = (s_tdata >= fsp_pkg::CH_ZERO) && (s_tdata <= fsp_pkg::CH_NINE);
    assign sum_pn   = add_digit(pn_reg, s_tdata);
    assign sum_pd   = add_digit(pd_reg, s_tdata);

    always_comb
    begin
        phase_next = phase_reg;
        pn_next    = pn_reg;
        pd_next    = pd_reg;
        neg_next   = neg_reg;
        ov_next    = ov_reg;
        do_start   = 1'b0;
        wr0_en     = 1'b0;
        wr1_en     = 1'b0;
        wr0_num    = pn_reg;
        wr0_den    = pd_reg;
        wr0_flags  = '{neg: neg_reg, ovf: ov_reg, last: 1'b0};
        wr1_num    = '0;
        wr1_den    = '0;
        wr1_flags  = '0;
        case (phase_reg)
            PH_NUM:
            begin
                if (is_dig)
                begin
                    pn_next = sum_pn[MW-1:0];
                    ov_next = ov_reg | sum_pn[MW];
                end
                else
                    phase_next = PH_DEN;
            end
            PH_DEN:
            begin
                if (is_dig)
                begin
                    pd_next = sum_pd[MW-1:0];
                    ov_next = ov_reg | sum_pd[MW];
                end
                else
                begin
                    // close the open fraction, then this char opens the next one
                    wr0_en   = 1'b1;
                    pn_next  = '0;
                    pd_next  = '0;
                    neg_next = 1'b0;
                    ov_next  = 1'b0;
                    do_start = 1'b1;
                end
            end
            default:
                do_start = 1'b1;
        endcase
        if (do_start)
        begin
            if ((s_tdata == fsp_pkg::CH_PLUS) || (s_tdata == fsp_pkg::CH_MINUS))
            begin
                neg_next   = (s_tdata == fsp_pkg::CH_MINUS);
                phase_next = PH_NUM;
            end
            else if (is_dig)
            begin
                pn_next    = MW'(s_tdata[3:0]);
                phase_next = PH_NUM;
            end
            else
                phase_next = PH_DEN;
        end
        if (s_tlast)
        begin
            if (wr0_en)
            begin
                wr1_en    = 1'b1;
                wr1_num   = pn_next;
                wr1_den   = pd_next;
                wr1_flags = '{neg: neg_next, ovf: ov_next, last: 1'b1};
            end
            else
            begin
                wr0_en    = 1'b1;
                wr0_num   = pn_next;
                wr0_den   = pd_next;
                wr0_flags = '{neg: neg_next, ovf: ov_next, last: 1'b1};
            end
            phase_next = PH_START;
            pn_next    = '0;
            pd_next    = '0;
            neg_next   = 1'b0;
            ov_next    = 1'b0;
        end
        if (!accept)
        begin
            wr0_en = 1'b0;
            wr1_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            pn_reg    <= '0;
            pd_reg    <= '0;
            neg_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pn_reg    <= pn_next;
            pd_reg    <= pd_next;
            neg_reg   <= neg_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fsp_queue.sv
// ---------------------------------------------------------------------------
// fsp_queue
// Fraction command queue, up to two writes and one read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module fsp_queue #(
    parameter int VALUE_WIDTH = fsp_pkg::VALUE_WIDTH,
    parameter int DEPTH       = fsp_pkg::QUEUE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr0_en,
    input  wire logic [VALUE_WIDTH-2:0]   wr0_num,
    input  wire logic [VALUE_WIDTH-2:0]   wr0_den,
    input  wire fsp_pkg::cmd_flags_t      wr0_flags,
    input  wire logic                     wr1_en,
    input  wire logic [VALUE_WIDTH-2:0]   wr1_num,
    input  wire logic [VALUE_WIDTH-2:0]   wr1_den,
    input  wire fsp_pkg::cmd_flags_t      wr1_flags,
    output logic                          space,
    output logic                          rd_valid,
    input  wire logic                     rd_pop,
    output logic [VALUE_WIDTH-2:0]        rd_num,
    output logic [VALUE_WIDTH-2:0]        rd_den,
    output fsp_pkg::cmd_flags_t           rd_flags,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    localparam int MW = VALUE_WIDTH - 1;
    localparam int DW = 2 * MW + $bits(fsp_pkg::cmd_flags_t);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] entry_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rd_word;
    logic          pop;

    assign pop      = rd_pop && (cnt_reg != '0);
    assign rd_valid = (cnt_reg != '0);
    assign space    = (cnt_reg <= CW'(DEPTH - 2));
    assign count    = cnt_reg;
    assign rd_word  = entry_reg[rp_reg];
    assign rd_num   = rd_word[DW-1 -: MW];
    assign rd_den   = rd_word[DW-1-MW -: MW];
    assign rd_flags = rd_word[$bits(fsp_pkg::cmd_flags_t)-1:0];

    always_ff @(posedge clk)
    begin
        if (wr0_en)
            entry_reg[wp_reg] <= {wr0_num, wr0_den, wr0_flags};
        if (wr1_en)
            entry_reg[wp_reg + PW'(1)] <= {wr1_num, wr1_den, wr1_flags};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + PW'(wr0_en) + PW'(wr1_en);
            rp_reg  <= rp_reg + PW'(pop);
            cnt_reg <= cnt_reg + CW'(wr0_en) + CW'(wr1_en) - CW'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: sv/fsp_back.sv
// ---------------------------------------------------------------------------
// fsp_back
// Adds fractions to the running total, reduces it and delivers results.
// ---------------------------------------------------------------------------
`default_nettype none

module fsp_back #(
    parameter int VALUE_WIDTH = fsp_pkg::VALUE_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    output logic                          q_pop,
    input  wire logic [VALUE_WIDTH-2:0]   q_num,
    input  wire logic [VALUE_WIDTH-2:0]   q_den,
    input  wire fsp_pkg::cmd_flags_t      q_flags,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [63:0]                   m_tdata,   // [31:0] sum_numerator, [62:32] sum_denominator
    output logic [1:0]                    m_tuser    // [0] overflow, [1] zero_denominator
);
    localparam int VW = VALUE_WIDTH;
    localparam int MW = VW - 1;
    localparam int P  = 2 * VW;
    localparam int KW = $clog2(P);
    localparam logic [P-1:0] MAXV = P'({MW{1'b1}});

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL1     = 4'd1;
    localparam logic [3:0] ST_MUL2     = 4'd2;
    localparam logic [3:0] ST_MUL3     = 4'd3;
    localparam logic [3:0] ST_GCD_INIT = 4'd4;
    localparam logic [3:0] ST_GCD      = 4'd5;
    localparam logic [3:0] ST_DIV_NUM  = 4'd6;
    localparam logic [3:0] ST_WAIT_NUM = 4'd7;
    localparam logic [3:0] ST_DIV_DEN  = 4'd8;
    localparam logic [3:0] ST_WAIT_DEN = 4'd9;
    localparam logic [3:0] ST_SAT      = 4'd10;
    localparam logic [3:0] ST_EMIT     = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic signed [VW-1:0] tn_reg, tn_next;
    logic [MW-1:0]       td_reg, td_next;
    logic                ovf_reg, ovf_next, zden_reg, zden_next;
    logic [MW-1:0]       cpn_reg, cpn_next, cpd_reg, cpd_next;
    logic                cneg_reg, cneg_next, clast_reg, clast_next;
    logic signed [P-1:0] acc_reg, acc_next, prod_reg, prod_next;
    logic [P-1:0]        den_reg, den_next, mag_reg, mag_next;
    logic                rneg_reg, rneg_next;
    logic [P-1:0]        a_reg, a_next, b_reg, b_next, g_reg, g_next;
    logic [KW-1:0]       k_reg, k_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_num_reg, out_num_next;
    logic [30:0]         out_den_reg, out_den_next;
    logic                out_ovf_reg, out_ovf_next, out_zden_reg, out_zden_next;

    logic signed [VW:0]     mul_a, mul_b;
    logic signed [2*VW+1:0] mul_p;
    logic                   div_start, div_done;
    logic [P-1:0]           div_q;

    assign mul_p = mul_a * mul_b;

    fsp_div #(.W(P)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ((state_reg == ST_DIV_DEN) ? den_reg : mag_reg),
        .divisor  (g_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        tn_next        = tn_reg;
        td_next        = td_reg;
        ovf_next       = ovf_reg;
        zden_next      = zden_reg;
        cpn_next       = cpn_reg;
        cpd_next       = cpd_reg;
        cneg_next      = cneg_reg;
        clast_next     = clast_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        mag_next       = mag_reg;
        rneg_next      = rneg_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        g_next         = g_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_ovf_next   = out_ovf_reg;
        out_zden_next  = out_zden_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        mul_a          = {{2{1'b0}}, cpn_reg};
        mul_b          = {{2{1'b0}}, td_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cpn_next   = q_num;
                    cpd_next   = q_den;
                    cneg_next  = q_flags.neg;
                    clast_next = q_flags.last;
                    ovf_next   = ovf_reg | q_flags.ovf;
                    if (q_den == '0)
                    begin
                        // total left as is
                        zden_next  = 1'b1;
                        state_next = q_flags.last ? ST_EMIT : ST_IDLE;
                    end
                    else
                        state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                mul_a      = {tn_reg[VW-1], tn_reg};
                mul_b      = {{2{1'b0}}, cpd_reg};
                acc_next   = P'(mul_p);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod_next  = cneg_reg ? -P'(mul_p) : P'(mul_p);
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                mul_a      = {{2{1'b0}}, td_reg};
                mul_b      = {{2{1'b0}}, cpd_reg};
                acc_next   = acc_reg + prod_reg;
                den_next   = P'(mul_p);
                state_next = ST_GCD_INIT;
            end
            ST_GCD_INIT:
            begin
                rneg_next  = acc_reg[P-1];
                mag_next   = acc_reg[P-1] ? P'(-acc_reg) : P'(acc_reg);
                a_next     = acc_reg[P-1] ? P'(-acc_reg) : P'(acc_reg);
                b_next     = den_reg;
                k_next     = '0;
                state_next = ST_GCD;
            end
            ST_GCD:
            begin
                // binary gcd, one shift or subtract per cycle
                if (a_reg == '0)
                begin
                    g_next     = b_reg << k_reg;
                    state_next = ST_DIV_NUM;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!a_reg[0])
                    a_next = a_reg >> 1;
                else if (!b_reg[0])
                    b_next = b_reg >> 1;
                else if (a_reg >= b_reg)
                    a_next = a_reg - b_reg;
                else
                    b_next = b_reg - a_reg;
            end
            ST_DIV_NUM:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_NUM;
            end
            ST_WAIT_NUM:
            begin
                if (div_done)
                begin
                    mag_next   = div_q;
                    state_next = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_DEN;
            end
            ST_WAIT_DEN:
            begin
                if (div_done)
                begin
                    den_next   = div_q;
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (rneg_reg)
                begin
                    if (mag_reg > MAXV + P'(1))
                    begin
                        tn_next  = {1'b1, {MW{1'b0}}};
                        ovf_next = 1'b1;
                    end
                    else
                        tn_next = VW'(P'(0) - mag_reg);
                end
                else if (mag_reg > MAXV)
                begin
                    tn_next  = {1'b0, {MW{1'b1}}};
                    ovf_next = 1'b1;
                end
                else
                    tn_next = VW'(mag_reg);
                if (den_reg > MAXV)
                begin
                    td_next  = {MW{1'b1}};
                    ovf_next = 1'b1;
                end
                else
                    td_next = MW'(den_reg);
                state_next = clast_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = 32'(tn_reg);
                    out_den_next   = 31'(td_reg);
                    out_ovf_next   = ovf_reg;
                    out_zden_next  = zden_reg;
                    tn_next        = '0;
                    td_next        = MW'(1);
                    ovf_next       = 1'b0;
                    zden_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tn_reg        <= '0;
            td_reg        <= MW'(1);
            ovf_reg       <= 1'b0;
            zden_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tn_reg        <= tn_next;
            td_reg        <= td_next;
            ovf_reg       <= ovf_next;
            zden_reg      <= zden_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cpn_reg      <= cpn_next;
        cpd_reg      <= cpd_next;
        cneg_reg     <= cneg_next;
        clast_reg    <= clast_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        den_reg      <= den_next;
        mag_reg      <= mag_next;
        rneg_reg     <= rneg_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        g_reg        <= g_next;
        k_reg        <= k_next;
        out_num_reg  <= out_num_next;
        out_den_reg  <= out_den_next;
        out_ovf_reg  <= out_ovf_next;
        out_zden_reg <= out_zden_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_den_reg, out_num_reg};
    assign m_tuser  = {out_zden_reg, out_ovf_reg};

endmodule

`default_nettype wire

FILE: sv/fraction_sum_parser.sv
// Adds a stream of signed fractions such as -1/2+1/3, one character per
// transfer, and returns the reduced sum once the character with tlast set has
// arrived. The parser takes one character per cycle as long as the fraction
// queue has room for two entries. Each completed fraction then passes the
// accumulator's multiply states MUL1 to MUL3, a binary GCD by shifts and
// subtractions and two serial divisions, of the numerator and denominator
// by the GCD; a fraction with a zero denominator skips these and leaves the
// total as it is. The result register holds a finished sum while the parser
// keeps taking characters.
// ---------------------------------------------------------------------------
// fraction_sum_parser
// Top level: character parser, fraction queue and rational accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

`include "fraction_sum_parser_assert.svh"

module fraction_sum_parser #(
    parameter int VALUE_WIDTH = fsp_pkg::VALUE_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] sum_numerator, [62:32] sum_denominator
    output logic [1:0]       m_tuser    // [0] overflow, [1] zero_denominator
);
    localparam int MW    = VALUE_WIDTH - 1;
    localparam int DEPTH = fsp_pkg::QUEUE_DEPTH;

    logic                         q_space, wr0_en, wr1_en, rd_valid, rd_pop;
    logic [MW-1:0]                wr0_num, wr0_den, wr1_num, wr1_den, rd_num, rd_den;
    fsp_pkg::cmd_flags_t          wr0_flags, wr1_flags, rd_flags;
    logic [$clog2(DEPTH+1)-1:0]   q_count;

    fsp_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_space   (q_space),
        .wr0_en    (wr0_en),
        .wr0_num   (wr0_num),
        .wr0_den   (wr0_den),
        .wr0_flags (wr0_flags),
        .wr1_en    (wr1_en),
        .wr1_num   (wr1_num),
        .wr1_den   (wr1_den),
        .wr1_flags (wr1_flags)
    );

    fsp_queue #(.VALUE_WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr0_en    (wr0_en),
        .wr0_num   (wr0_num),
        .wr0_den   (wr0_den),
        .wr0_flags (wr0_flags),
        .wr1_en    (wr1_en),
        .wr1_num   (wr1_num),
        .wr1_den   (wr1_den),
        .wr1_flags (wr1_flags),
        .space     (q_space),
        .rd_valid  (rd_valid),
        .rd_pop    (rd_pop),
        .rd_num    (rd_num),
        .rd_den    (rd_den),
        .rd_flags  (rd_flags),
        .count     (q_count)
    );

    fsp_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (rd_valid),
        .q_pop    (rd_pop),
        .q_num    (rd_num),
        .q_den    (rd_den),
        .q_flags  (rd_flags),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `FSP_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_count <= DEPTH, "fraction queue overrun")
    `FSP_ASSERT_IMPL(a_ready_room, clk, rst_n, s_tready, q_count <= DEPTH - 2, "no room")
    `FSP_ASSERT_IMPL(a_den_nonzero, clk, rst_n, m_tvalid, m_tdata[62:32] != 31'd0, "zero den")

endmodule

`default_nettype wire

FILE: tb/fraction_sum_parser_test.sv
// ---------------------------------------------------------------------------
// fraction_sum_parser_test
// Drives signed fraction sums and noise bytes into the parser, predicts the
// reduced sum and flags of every expression and checks each result transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module fraction_sum_parser_test;

    localparam int VW = fsp_pkg::VALUE_WIDTH;
    localparam longint MAXV = (64'd1 << (VW - 1)) - 1;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        ovf;
        logic        zden;
    } sum_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       known;
        sum_t       want;
    } row_t;

    typedef enum logic [1:0] {AT_START, IN_NUM, IN_DEN} phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;   // [31:0] sum_numerator, [62:32] sum_denominator
    logic [1:0]  m_tuser;   // [0] overflow, [1] zero_denominator

    fraction_sum_parser dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    // predictor state
    longint     acc_num, acc_den;
    longint     frac_num, frac_den;
    logic       frac_neg, ovf_seen, zden_seen;
    phase_t     ph;

    sum_t       sums_due[$];
    logic       known_q[$];
    sum_t       typed_q[$];
    int         errors = 0;
    int         send_idle = 17, recv_idle = 65;
    bit         hold_off = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit is_dig(logic [7:0] c);
        return c >= fsp_pkg::CH_ZERO && c <= fsp_pkg::CH_NINE;
    endfunction

    function automatic longint push_digit(longint a, logic [7:0] c);
        longint v;
        v = a * fsp_pkg::RADIX + (c - fsp_pkg::CH_ZERO);
        if (v > MAXV)
        begin
            ovf_seen = 1;
            v = MAXV;
        end
        return v;
    endfunction

    function automatic void clear_sum();
        acc_num = 0; acc_den = 1; frac_num = 0; frac_den = 0;
        frac_neg = 0; ph = AT_START; ovf_seen = 0; zden_seen = 0;
    endfunction

    function automatic void close_fraction();
        longint pn, n, d, a, b, t;
        longint unsigned mag;
        if (frac_den == 0)
            zden_seen = 1;
        else
        begin
            pn = frac_neg ? -frac_num : frac_num;
            n = acc_num * frac_den + pn * acc_den;
            d = acc_den * frac_den;
            mag = n < 0 ? -n : n;
            a = mag; b = d;
            while (b != 0)
            begin
                t = a % b; a = b; b = t;
            end
            if (a == 0) a = 1;
            mag = mag / a;
            d = d / a;
            if (n < 0)
            begin
                if (mag > MAXV + 1)
                begin
                    mag = MAXV + 1; ovf_seen = 1;
                end
                n = -longint'(mag);
            end
            else
            begin
                if (mag > MAXV)
                begin
                    mag = MAXV; ovf_seen = 1;
                end
                n = mag;
            end
            if (d > MAXV)
            begin
                d = MAXV; ovf_seen = 1;
            end
            acc_num = n; acc_den = d;
        end
        frac_num = 0; frac_den = 0; frac_neg = 0; ph = AT_START;
    endfunction

    function automatic void open_char(logic [7:0] c);
        if (c == fsp_pkg::CH_PLUS || c == fsp_pkg::CH_MINUS)
        begin
            frac_neg = (c == fsp_pkg::CH_MINUS); ph = IN_NUM;
        end
        else if (is_dig(c))
        begin
            frac_num = push_digit(frac_num, c); ph = IN_NUM;
        end
        else
            ph = IN_DEN;
    endfunction

    // returns 1 and the sum when the character closes the expression
    function automatic bit parse_char(logic [7:0] c, logic lst, output sum_t s);
        s = '0;
        case (ph)
            IN_NUM:  if (is_dig(c)) frac_num = push_digit(frac_num, c); else ph = IN_DEN;
            IN_DEN:
                if (is_dig(c)) frac_den = push_digit(frac_den, c);
                else
                begin
                    close_fraction(); open_char(c);
                end
            default: open_char(c);
        endcase
        if (!lst) return 0;
        close_fraction();
        s.num = acc_num[31:0]; s.den = acc_den[30:0];
        s.ovf = ovf_seen; s.zden = zden_seen;
        clear_sum();
        return 1;
    endfunction

    // valid stays up between back-to-back transfers; idle cycles drop it
    task automatic send(input logic [7:0] c, input logic lst, input logic known, input sum_t w);
        sum_t s;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1; s_tdata <= c; s_tlast <= lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (parse_char(c, lst, s))
        begin
            sums_due.push_back(s); known_q.push_back(known); typed_q.push_back(w);
        end
        @(negedge clk);
    endtask

    task automatic send_str(input string e);
        for (int i = 0; i < e.len(); i++)
            send(e[i], i == e.len() - 1, 0, '0);
    endtask

    function automatic string digits(int n);
        string s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'h30 + $urandom_range(9))};
        return s;
    endfunction

    function automatic string rand_expr();
        string e = "";
        int nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++)
        begin
            case ($urandom_range(3))
                0: e = {e, "-"};
                1: e = {e, "+"};
                default: if (f > 0) e = {e, "+"};
            endcase
            e = {e, digits($urandom_range(1, $urandom_range(9) == 0 ? 12 : 3)), "/"};
            e = {e, $urandom_range(15) == 0 ? "0" : {string'(8'h31 + $urandom_range(8)),
                 digits($urandom_range(0, $urandom_range(9) == 0 ? 11 : 2))}};
        end
        return e;
    endfunction

    // receiver
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (sums_due.size() == 0)
                report("unexpected result", m_tdata, 0);
            else
            begin
                sum_t w;
                w = sums_due.pop_front();
                if (known_q.pop_front())
                    w = typed_q[0];
                void'(typed_q.pop_front());
                if (m_tdata[31:0] !== w.num) report("sum_numerator", m_tdata[31:0], w.num);
                if (m_tdata[62:32] !== w.den) report("sum_denominator", m_tdata[62:32], w.den);
                if (m_tdata[63] !== 1'b0) report("tdata pad", m_tdata[63], 0);
                if (m_tuser[0] !== w.ovf) report("overflow", m_tuser[0], w.ovf);
                if (m_tuser[1] !== w.zden) report("zero_denominator", m_tuser[1], w.zden);
            end
        end
    end

    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

    initial
    begin
        #30000000;
        $display("*** FAILED ***");
        $finish;
    end

    row_t rows[$];

    function automatic sum_t mk(logic [31:0] n, logic [30:0] d, logic o, logic z);
        sum_t s;
        s.num = n; s.den = d; s.ovf = o; s.zden = z;
        return s;
    endfunction

    task automatic add_row(input string e, input logic known, input sum_t w);
        row_t r;
        for (int i = 0; i < e.len(); i++)
        begin
            r.ch = e[i]; r.last = (i == e.len() - 1);
            r.known = r.last && known; r.want = w;
            rows.push_back(r);
        end
    endtask

    initial
    begin
        int n;
        int k;
        string e;
        clear_sum();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_row("0", 1, mk(0, 1, 0, 1));                  // missing denominator
        add_row("-1/2+1/3", 1, mk(-32'sd1, 6, 0, 0));
        add_row("5/0", 1, mk(0, 1, 0, 1));
        add_row("99999999999/1", 1, mk(32'h7fffffff, 1, 1, 0));
        add_row("-9999999999/1", 1, mk(32'h80000001, 1, 1, 0));
        add_row("1/2147483647+1/2", 0, '0);
        add_row("1/3/4", 0, '0);
        add_row("+-7\xff\x00", 0, '0);
        foreach (rows[i])
            send(rows[i].ch, rows[i].last, rows[i].known, rows[i].want);

        n = 0;
        for (int phs = 0; phs < 3; phs++)
        begin
            send_idle = phs == 0 ? 17 : (phs == 1 ? 65 : 0);
            recv_idle = phs == 0 ? 65 : (phs == 1 ? 17 : 0);
            if (phs == 1)
            begin
                // stall the receiver long enough for the block to back up
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge clk);
                        hold_off = 0;
                    end
                    begin
                        repeat (6) send_str("1/2+1/3");
                        s_tvalid <= 1'b0;
                    end
                join
                @(negedge clk);
            end
            while (n < 580 * (phs + 1))
            begin
                if ($urandom_range(9) == 0)
                begin
                    // noise: arbitrary bytes
                    k = $urandom_range(1, 6);
                    for (int i = 0; i < k; i++)
                        send(8'($urandom_range(255)), i == k - 1, 0, '0);
                    n += k;
                end
                else
                begin
                    e = rand_expr();
                    send_str(e);
                    n += e.len();
                end
            end
        end
        s_tvalid <= 1'b0;

        while (sums_due.size() != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
        if (errors == 0 && sums_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/fsp_pkg.sv
sv/fsp_div.sv
sv/fsp_front.sv
sv/fsp_queue.sv
sv/fsp_back.sv
sv/fraction_sum_parser.sv
tb/fraction_sum_parser_test.sv
